// ----- rtl/core/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, character codes and helper functions for the JSON string
// unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int CODE_W          = 16;
  localparam int HEX_DIGIT_COUNT = 4;
  localparam int HEX_CNT_W       = $clog2(HEX_DIGIT_COUNT);

  localparam logic [CODE_W-1:0] CH_BACKSLASH = 16'h005C;
  localparam logic [CODE_W-1:0] CH_QUOTE     = 16'h0027;
  localparam logic [CODE_W-1:0] CH_DQUOTE    = 16'h0022;
  localparam logic [CODE_W-1:0] CH_U         = 16'h0075;
  localparam logic [CODE_W-1:0] CH_T         = 16'h0074;
  localparam logic [CODE_W-1:0] CH_F         = 16'h0066;
  localparam logic [CODE_W-1:0] CH_B         = 16'h0062;
  localparam logic [CODE_W-1:0] CH_N         = 16'h006E;
  localparam logic [CODE_W-1:0] CH_R         = 16'h0072;
  localparam logic [CODE_W-1:0] CH_TAB       = 16'h0009;
  localparam logic [CODE_W-1:0] CH_FF        = 16'h000C;
  localparam logic [CODE_W-1:0] CH_BS        = 16'h0008;
  localparam logic [CODE_W-1:0] CH_LF        = 16'h000A;
  localparam logic [CODE_W-1:0] CH_CR        = 16'h000D;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_ESCAPE  = 2'd1,
    MODE_HEX     = 2'd2,
    MODE_DISCARD = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t                 mode;
    logic [CODE_W-1:0]     hex_value;
    logic [HEX_CNT_W-1:0]  hex_count;
  } state_t;

  typedef struct packed {
    logic                  emit;
    logic [CODE_W-1:0]     code;
    logic                  has_char;
    logic                  error;
    logic                  eos;
  } result_t;

  // Bit 4 set: not a hex digit.
  function automatic logic [4:0] hex_nibble(input logic [CODE_W-1:0] c);
    logic [4:0] nib;
    nib = 5'h10;
    if (c inside {[16'h0030:16'h0039]}) begin
      nib = {1'b0, c[3:0]};
    end else if (c inside {[16'h0061:16'h0066], [16'h0041:16'h0046]}) begin
      nib = {1'b0, c[3:0] + 4'd9};
    end
    return nib;
  endfunction

  function automatic logic [CODE_W-1:0] escape_map(input logic [CODE_W-1:0] c);
    logic [CODE_W-1:0] m;
    case (c)
      CH_QUOTE:  m = CH_QUOTE;
      CH_DQUOTE: m = CH_DQUOTE;
      CH_T:      m = CH_TAB;
      CH_F:      m = CH_FF;
      CH_B:      m = CH_BS;
      CH_N:      m = CH_LF;
      CH_R:      m = CH_CR;
      default:   m = CH_BACKSLASH;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/core/jsu_decode.sv -----
// ----------------------------------------------------------------------------
// jsu_decode
// One step of the unescape state machine: current state and one code unit
// in, next state and at most one result word out. Pure combinational.
// ----------------------------------------------------------------------------
module jsu_decode (
  input  jsu_pkg::state_t              st,
  input  logic [jsu_pkg::CODE_W-1:0]   code_in,
  input  logic                         is_last,
  output jsu_pkg::state_t              st_next,
  output jsu_pkg::result_t             res
);

  localparam jsu_pkg::state_t ST_CLEAR = '{
    mode:      jsu_pkg::MODE_NORMAL,
    hex_value: '0,
    hex_count: '0
  };

  logic [4:0]                     nib;
  logic [jsu_pkg::CODE_W-1:0]     hex_shift;
  logic                           hex_done;

  assign nib       = jsu_pkg::hex_nibble(code_in);
  assign hex_shift = {st.hex_value[jsu_pkg::CODE_W-5:0], nib[3:0]};
  assign hex_done  = (st.hex_count ==
                      jsu_pkg::HEX_CNT_W'(jsu_pkg::HEX_DIGIT_COUNT - 1));

  always_comb begin
    st_next = st;
    res     = '0;
    case (st.mode)
      jsu_pkg::MODE_NORMAL: begin
        if (code_in == jsu_pkg::CH_BACKSLASH && !is_last) begin
          st_next.mode = jsu_pkg::MODE_ESCAPE;
        end else begin
          res = '{emit: 1'b1, code: code_in, has_char: 1'b1, error: 1'b0,
                  eos: is_last};
          if (is_last) st_next = ST_CLEAR;
        end
      end
      jsu_pkg::MODE_ESCAPE: begin
        if (code_in == jsu_pkg::CH_U) begin
          if (is_last) begin
            st_next = ST_CLEAR;
            res = '{emit: 1'b1, code: '0, has_char: 1'b0, error: 1'b1, eos: 1'b1};
          end else begin
            st_next = '{mode: jsu_pkg::MODE_HEX, hex_value: '0, hex_count: '0};
          end
        end else begin
          st_next = ST_CLEAR;
          res = '{emit: 1'b1, code: jsu_pkg::escape_map(code_in), has_char: 1'b1,
                  error: 1'b0, eos: is_last};
        end
      end
      jsu_pkg::MODE_HEX: begin
        if (nib[4]) begin
          if (is_last) begin
            st_next = ST_CLEAR;
            res = '{emit: 1'b1, code: '0, has_char: 1'b0, error: 1'b1, eos: 1'b1};
          end else begin
            st_next = '{mode: jsu_pkg::MODE_DISCARD, hex_value: '0, hex_count: '0};
          end
        end else if (hex_done) begin
          st_next = ST_CLEAR;
          res = '{emit: 1'b1, code: hex_shift, has_char: 1'b1, error: 1'b0,
                  eos: is_last};
        end else if (is_last) begin
          st_next = ST_CLEAR;
          res = '{emit: 1'b1, code: '0, has_char: 1'b0, error: 1'b1, eos: 1'b1};
        end else begin
          st_next.hex_value = hex_shift;
          st_next.hex_count = st.hex_count + jsu_pkg::HEX_CNT_W'(1);
        end
      end
      jsu_pkg::MODE_DISCARD: begin
        if (is_last) begin
          st_next = ST_CLEAR;
          res = '{emit: 1'b1, code: '0, has_char: 1'b0, error: 1'b1, eos: 1'b1};
        end
      end
      default: begin
        st_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- rtl/core/json_string_unescape.sv -----
// ----------------------------------------------------------------------------
// json_string_unescape
// An accepted input word's result word, if any, is registered at the output.
// Throughput: one word per cycle unless out_ready stalls; set by the decode step
// and the output register, which takes a new result while the old one drains.
// Reset (rst, synchronous): decoder back to normal mode, output empty.
// ----------------------------------------------------------------------------
module json_string_unescape (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [jsu_pkg::CODE_W-1:0]  code_in,
  input  logic                        is_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [jsu_pkg::CODE_W-1:0]  code_out,
  output logic                        has_char,
  output logic                        error,
  output logic                        end_of_string
);

  jsu_pkg::state_t  st;
  jsu_pkg::state_t  st_next;
  jsu_pkg::result_t res;
  logic             in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  jsu_decode u_decode (
    .st      (st),
    .code_in (code_in),
    .is_last (is_last),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '{mode: jsu_pkg::MODE_NORMAL, hex_value: '0, hex_count: '0};
      out_valid <= 1'b0;
    end else begin
      if (in_fire) st <= st_next;
      if (in_fire) begin
        out_valid <= res.emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res.emit) begin
      code_out      <= res.code;
      has_char      <= res.has_char;
      error         <= res.error;
      end_of_string <= res.eos;
    end
  end

endmodule

// ----- rtl/core/jsu_checker.sv -----
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks for the JSON string unescaper, bound to the top level.
// ----------------------------------------------------------------------------
module jsu_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [jsu_pkg::CODE_W-1:0]  code_out,
  input logic                        has_char,
  input logic                        error,
  input logic                        end_of_string
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_out) &&
    $stable(end_of_string))
    else $error("result word changed while stalled");

  a_err_eos: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> end_of_string && !has_char)
    else $error("error outside an end marker");

  a_no_char_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_char |-> code_out == '0 && error)
    else $error("empty word carries a code or lacks the error flag");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result word present right after reset");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .code_out      (code_out),
  .has_char      (has_char),
  .error         (error),
  .end_of_string (end_of_string)
);
